### src/jftm_pkg.sv
// ----------------------------------------------------------------------------
// Joystick frame thruster mixer package
// Constants and types shared by the mixer and its port checker.
// ----------------------------------------------------------------------------
package jftm_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned NUM_AXES     = 6;
  localparam int unsigned AXIS_IDX_W   = 3;
  localparam int unsigned FRAME_BYTES  = 14;
  localparam int unsigned AXIS_BYTES   = 12;

  localparam int unsigned NEUTRAL_W    = 11;
  localparam int unsigned GAIN_W       = 9;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned WIDTH_W      = 12;

  localparam int unsigned NUM_THR      = 6;
  localparam int unsigned NUM_HORIZ    = 4;
  localparam int unsigned SUM_W        = 18;
  localparam int unsigned MAG_W        = 17;
  localparam int unsigned PROD_W       = MAG_W + GAIN_W;
  localparam int unsigned H_SHIFT      = 16;
  localparam int unsigned V_SHIFT      = 17;
  localparam int unsigned HI_W         = PROD_W - H_SHIFT;
  localparam int unsigned Q_W          = PROD_W - V_SHIFT;
  localparam int unsigned RECIP3       = 683;
  localparam int unsigned RECIP3_W     = 10;
  localparam int unsigned RECIP3_SHIFT = 11;
  localparam int unsigned RES_W        = WIDTH_W + 1;

  localparam logic [CFG_IDX_W-1:0]  CFG_NEUTRAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_GAIN    = 1'd1;
  localparam logic [NEUTRAL_W-1:0]  NEUTRAL_RST = 11'd1500;
  localparam logic [GAIN_W-1:0]     GAIN_RST    = 9'd200;

  typedef enum logic [AXIS_IDX_W-1:0] {
    AX_LX = 3'd0,
    AX_LY = 3'd1,
    AX_LZ = 3'd2,
    AX_RX = 3'd3,
    AX_RY = 3'd4,
    AX_RZ = 3'd5
  } axis_t;

  typedef struct packed {
    logic [WORD_W-1:0] buttons;
    logic              armed;
    logic              frame_done;
  } meta_t;

endpackage

### src/joystick_frame_thruster_mixer.sv
// ----------------------------------------------------------------------------
// Joystick frame thruster mixer
// Assembles command frame bytes and mixes the axes into six thruster widths.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock and returns one result beat per
// byte, through three registered stages: a byte assembly and axis sum stage,
// a gain multiply stage, and a scaling stage that divides by the split and
// adds the neutral width. The three stages advance together whenever the
// output register is empty or being taken, so a new byte is accepted in
// every cycle in which the result side does not stall.
module joystick_frame_thruster_mixer
  import jftm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WIDTH_W-1:0]    out_front_right_width,
  output logic [WIDTH_W-1:0]    out_front_left_width,
  output logic [WIDTH_W-1:0]    out_back_right_width,
  output logic [WIDTH_W-1:0]    out_back_left_width,
  output logic [WIDTH_W-1:0]    out_right_vertical_width,
  output logic [WIDTH_W-1:0]    out_left_vertical_width,
  output logic [WORD_W-1:0]     out_buttons,
  output logic                  out_armed,
  output logic                  out_frame_done
);

  logic [NEUTRAL_W-1:0] neutral_r;
  logic [GAIN_W-1:0]    gain_r;

  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [WORD_W-1:0]    axes_r [NUM_AXES];
  logic [WORD_W-1:0]    axes_nxt [NUM_AXES];
  logic [WORD_W-1:0]    btn_r, btn_nxt;
  logic                 armed_r, armed_nxt;
  logic                 done_nxt;

  logic                 advance, accept;
  logic                 v1_r, v2_r, out_valid_r;

  logic signed [SUM_W-1:0] sum [NUM_THR];
  logic [MAG_W-1:0]     mag_nxt [NUM_THR];
  logic [MAG_W-1:0]     mag_r [NUM_THR];
  logic [NUM_THR-1:0]   neg_nxt, neg1_r, neg2_r;
  meta_t                meta1_r, meta2_r, meta_out_r;

  logic [PROD_W-1:0]    prod_nxt [NUM_THR];
  logic [PROD_W-1:0]    prod_r [NUM_THR];

  logic [WIDTH_W-1:0]   width_nxt [NUM_THR];
  logic [WIDTH_W-1:0]   width_r [NUM_THR];

  logic signed [SUM_W-1:0] lx, ly, lz, ry, rz;
  logic [AXIS_IDX_W-1:0]   ax_idx;

  assign advance  = !out_valid_r || out_ready;
  assign accept   = in_valid && advance;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= NEUTRAL_RST;
      gain_r    <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEUTRAL: neutral_r <= cfg_wdata[NEUTRAL_W-1:0];
        CFG_GAIN:    gain_r    <= cfg_wdata[GAIN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    axes_nxt = axes_r;
    btn_nxt  = btn_r;
    ax_idx   = pos_r[POS_W-1:1];
    if (pos_r < POS_W'(AXIS_BYTES)) begin
      if (!pos_r[0]) begin
        axes_nxt[ax_idx] = {in_rx_byte, BYTE_W'(0)};
      end else begin
        axes_nxt[ax_idx] = axes_r[ax_idx] | {BYTE_W'(0), in_rx_byte};
      end
    end else begin
      if (!pos_r[0]) begin
        btn_nxt = {in_rx_byte, BYTE_W'(0)};
      end else begin
        btn_nxt = btn_r | {BYTE_W'(0), in_rx_byte};
      end
    end
    done_nxt = (pos_r == POS_W'(FRAME_BYTES - 1));
    if (pos_r >= POS_W'(FRAME_BYTES - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
    armed_nxt = armed_r || (btn_nxt != '0);
  end

  always_comb begin
    lx = SUM_W'(signed'(axes_nxt[AX_LX]));
    ly = SUM_W'(signed'(axes_nxt[AX_LY]));
    lz = SUM_W'(signed'(axes_nxt[AX_LZ]));
    ry = SUM_W'(signed'(axes_nxt[AX_RY]));
    rz = SUM_W'(signed'(axes_nxt[AX_RZ]));
    sum[0] = -lx + ly - rz;
    sum[1] =  lx + ly + rz;
    sum[2] =  lx - ly - rz;
    sum[3] = -lx - ly + rz;
    sum[4] = -lz + ry;
    sum[5] = -lz - ry;
    for (int i = 0; i < NUM_THR; i++) begin
      neg_nxt[i] = sum[i][SUM_W-1];
      if (sum[i][SUM_W-1]) begin
        mag_nxt[i] = MAG_W'(-sum[i]);
      end else begin
        mag_nxt[i] = MAG_W'(sum[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_THR; i++) begin
      prod_nxt[i] = PROD_W'(mag_r[i]) * PROD_W'(gain_r);
    end
  end

  always_comb begin
    logic [HI_W-1:0]             hi;
    logic [HI_W+RECIP3_W-1:0]    scaled;
    logic [Q_W-1:0]              q;
    logic signed [RES_W-1:0]     res;
    for (int i = 0; i < NUM_THR; i++) begin
      hi     = prod_r[i][PROD_W-1:H_SHIFT];
      scaled = (HI_W+RECIP3_W)'(hi) * (HI_W+RECIP3_W)'(RECIP3);
      if (i < NUM_HORIZ) begin
        q = scaled[RECIP3_SHIFT +: Q_W];
      end else begin
        q = prod_r[i][PROD_W-1:V_SHIFT];
      end
      if (neg2_r[i]) begin
        res = RES_W'(neutral_r) - RES_W'(q);
      end else begin
        res = RES_W'(neutral_r) + RES_W'(q);
      end
      if (!meta2_r.armed) begin
        width_nxt[i] = WIDTH_W'(neutral_r);
      end else if (res[RES_W-1]) begin
        width_nxt[i] = '0;
      end else begin
        width_nxt[i] = res[WIDTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      btn_r       <= '0;
      armed_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axes_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        pos_r   <= pos_nxt;
        btn_r   <= btn_nxt;
        armed_r <= armed_nxt;
        axes_r  <= axes_nxt;
      end
      if (advance) begin
        v1_r        <= in_valid;
        v2_r        <= v1_r;
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mag_r      <= mag_nxt;
      neg1_r     <= neg_nxt;
      meta1_r    <= '{buttons: btn_nxt, armed: armed_nxt, frame_done: done_nxt};
      prod_r     <= prod_nxt;
      neg2_r     <= neg1_r;
      meta2_r    <= meta1_r;
      width_r    <= width_nxt;
      meta_out_r <= meta2_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_front_right_width    = width_r[0];
  assign out_front_left_width     = width_r[1];
  assign out_back_right_width     = width_r[2];
  assign out_back_left_width      = width_r[3];
  assign out_right_vertical_width = width_r[4];
  assign out_left_vertical_width  = width_r[5];
  assign out_buttons              = meta_out_r.buttons;
  assign out_armed                = meta_out_r.armed;
  assign out_frame_done           = meta_out_r.frame_done;

endmodule

### src/jftm_checker.sv
// ----------------------------------------------------------------------------
// Joystick frame thruster mixer port checker
// Watches the mixer ports over time and flags inconsistent behavior.
// ----------------------------------------------------------------------------
module jftm_port_props
  import jftm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [WIDTH_W-1:0]    out_front_right_width,
  input logic [WIDTH_W-1:0]    out_front_left_width,
  input logic [WIDTH_W-1:0]    out_back_right_width,
  input logic [WIDTH_W-1:0]    out_back_left_width,
  input logic [WIDTH_W-1:0]    out_right_vertical_width,
  input logic [WIDTH_W-1:0]    out_left_vertical_width,
  input logic [WORD_W-1:0]     out_buttons,
  input logic                  out_armed,
  input logic                  out_frame_done
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_buttons)
      && $stable(out_armed) && $stable(out_frame_done)
      && $stable(out_front_right_width) && $stable(out_left_vertical_width))
    else $error("result beat changed while stalled");

  // The input side only stalls while a finished result waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // A nonzero button word always arms the block.
  a_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_buttons != '0 |-> out_armed)
    else $error("nonzero buttons while not armed");

  // Unarmed results hold all thrusters at the same neutral width.
  a_neutral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_armed |->
      out_front_right_width == out_front_left_width
      && out_front_right_width == out_back_right_width
      && out_front_right_width == out_back_left_width
      && out_front_right_width == out_right_vertical_width
      && out_front_right_width == out_left_vertical_width)
    else $error("unarmed widths differ");

endmodule

bind joystick_frame_thruster_mixer jftm_port_props u_jftm_port_props (.*);

### bench/jftm_checker.sv
// ----------------------------------------------------------------------------
// Thruster mixer port checker
// Watches the configuration port and both beat channels of the mixer. Every
// accepted frame byte is run through a local copy of the frame assembly,
// arming and mixing arithmetic, and each result beat is compared field by
// field with the oldest predicted beat. The number of outstanding
// predictions and the mismatch count are handed back to the bench top.
// ----------------------------------------------------------------------------
module jftm_checker
  import jftm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [WIDTH_W-1:0]    out_front_right_width,
  input  logic [WIDTH_W-1:0]    out_front_left_width,
  input  logic [WIDTH_W-1:0]    out_back_right_width,
  input  logic [WIDTH_W-1:0]    out_back_left_width,
  input  logic [WIDTH_W-1:0]    out_right_vertical_width,
  input  logic [WIDTH_W-1:0]    out_left_vertical_width,
  input  logic [WORD_W-1:0]     out_buttons,
  input  logic                  out_armed,
  input  logic                  out_frame_done,
  output int                    outstanding,
  output int                    mismatches
);

  localparam int HORIZ_DIV   = 3 << H_SHIFT;
  localparam int VERT_DIV    = 2 << H_SHIFT;
  localparam int WIDTH_MAX   = (1 << WIDTH_W) - 1;

  typedef struct packed {
    logic [NUM_THR-1:0][WIDTH_W-1:0] widths;
    meta_t                           meta;
  } thrust_beat_t;

  logic [NEUTRAL_W-1:0] neutral_q;
  logic [GAIN_W-1:0]    gain_q;
  logic [POS_W-1:0]     frame_pos;
  logic [WORD_W-1:0]    axes [NUM_AXES];
  logic [WORD_W-1:0]    button_word;
  logic                 armed_q;
  thrust_beat_t         expected_beats [$];

  string thr_name [NUM_THR] = '{"front_right_width", "front_left_width",
                                "back_right_width", "back_left_width",
                                "right_vertical_width", "left_vertical_width"};

  function automatic int axis_val(input axis_t ax);
    return int'($signed(axes[ax]));
  endfunction

  function automatic logic [WIDTH_W-1:0] scaled_width(input int sum, input int split);
    int prod;
    int mag;
    int q;
    int w;
    prod = sum * int'(gain_q);
    mag  = (prod < 0) ? -prod : prod;
    q    = mag / split;
    if (prod < 0) q = -q;
    w = int'(neutral_q) + q;
    if (w < 0) w = 0;
    if (w > WIDTH_MAX) w = WIDTH_MAX;
    return w[WIDTH_W-1:0];
  endfunction

  function automatic thrust_beat_t predict_beat(input logic [BYTE_W-1:0] b);
    thrust_beat_t r;
    int           a;
    int           lx;
    int           ly;
    int           lz;
    int           ry;
    int           rz;
    r.meta.frame_done = 1'b0;
    if (frame_pos < AXIS_BYTES) begin
      a = int'(frame_pos >> 1);
      if (!frame_pos[0]) axes[a] = {b, 8'h00};
      else axes[a] = axes[a] | {8'h00, b};
    end else begin
      if (!frame_pos[0]) button_word = {b, 8'h00};
      else button_word = button_word | {8'h00, b};
    end
    if (frame_pos >= FRAME_BYTES - 1) begin
      r.meta.frame_done = (frame_pos == FRAME_BYTES - 1);
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
    if (button_word != '0) armed_q = 1'b1;
    if (armed_q) begin
      lx = axis_val(AX_LX);
      ly = axis_val(AX_LY);
      lz = axis_val(AX_LZ);
      ry = axis_val(AX_RY);
      rz = axis_val(AX_RZ);
      r.widths[0] = scaled_width(-lx + ly - rz, HORIZ_DIV);
      r.widths[1] = scaled_width(lx + ly + rz, HORIZ_DIV);
      r.widths[2] = scaled_width(lx - ly - rz, HORIZ_DIV);
      r.widths[3] = scaled_width(-lx - ly + rz, HORIZ_DIV);
      r.widths[4] = scaled_width(-lz + ry, VERT_DIV);
      r.widths[5] = scaled_width(-lz - ry, VERT_DIV);
    end else begin
      for (int i = 0; i < NUM_THR; i++) r.widths[i] = {1'b0, neutral_q};
    end
    r.meta.buttons = button_word;
    r.meta.armed   = armed_q;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches = mismatches + 1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    thrust_beat_t     want;
    logic [WIDTH_W-1:0] seen [NUM_THR];
    if (!rst_n) begin
      neutral_q   = NEUTRAL_RST;
      gain_q      = GAIN_RST;
      frame_pos   = '0;
      button_word = '0;
      armed_q     = 1'b0;
      foreach (axes[i]) axes[i] = '0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEUTRAL: neutral_q = cfg_wdata[NEUTRAL_W-1:0];
          CFG_GAIN:    gain_q    = cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_beats.push_back(predict_beat(in_rx_byte));
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: unexpected result beat, expected none, actual buttons %0d",
                   $time, out_buttons);
        end else begin
          want    = expected_beats.pop_front();
          seen[0] = out_front_right_width;
          seen[1] = out_front_left_width;
          seen[2] = out_back_right_width;
          seen[3] = out_back_left_width;
          seen[4] = out_right_vertical_width;
          seen[5] = out_left_vertical_width;
          for (int i = 0; i < NUM_THR; i++) begin
            compare_field(thr_name[i], {4'h0, want.widths[i]}, {4'h0, seen[i]});
          end
          compare_field("buttons", want.meta.buttons, out_buttons);
          compare_field("armed", {15'h0, want.meta.armed}, {15'h0, out_armed});
          compare_field("frame_done", {15'h0, want.meta.frame_done}, {15'h0, out_frame_done});
        end
      end
    end
    outstanding <= expected_beats.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Thruster mixer testbench
// Feeds command frame bytes to the mixer: a directed opening that checks the
// unarmed state, arming on a partial button word and the axis extremes, then
// random frames under several neutral width and gain settings, including
// saturation below zero. Both channels idle at random and the result side
// applies a long hold-off. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench
  import jftm_pkg::*;
();

  localparam int PHASES         = 7;
  localparam int BEATS_PER_PHASE = 180;
  localparam int LONG_HOLD      = 60;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_NEUTRAL;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [WIDTH_W-1:0]    out_front_right_width;
  logic [WIDTH_W-1:0]    out_front_left_width;
  logic [WIDTH_W-1:0]    out_back_right_width;
  logic [WIDTH_W-1:0]    out_back_left_width;
  logic [WIDTH_W-1:0]    out_right_vertical_width;
  logic [WIDTH_W-1:0]    out_left_vertical_width;
  logic [WORD_W-1:0]     out_buttons;
  logic                  out_armed;
  logic                  out_frame_done;
  int                    outstanding;
  int                    mismatches;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_reqs = 0;

  logic [BYTE_W-1:0] opening_bytes [2 * FRAME_BYTES] = '{
    8'h80, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h55, 8'hAA, 8'h7F, 8'hFF,
    8'h80, 8'h00, 8'h01, 8'h00,
    8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h00,
    8'h7F, 8'hFF, 8'h00, 8'h00
  };

  joystick_frame_thruster_mixer u_top (.*);

  jftm_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_side
    int held;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != holds_done) begin
        holds_done = hold_off_reqs;
        out_ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_config(input logic [NEUTRAL_W-1:0] nw, input logic [GAIN_W-1:0] gn);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NEUTRAL;
    cfg_wdata <= CFG_DATA_W'(nw);
    @(posedge clk);
    cfg_index <= CFG_GAIN;
    cfg_wdata <= CFG_DATA_W'(gn);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [NEUTRAL_W-1:0] nw;
    logic [GAIN_W-1:0]    gn;
    int                   mode;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin nw = 11'd1000; gn = 9'd500; end
        1: begin nw = 11'd2000; gn = 9'd0; end
        2: begin nw = 11'd0; gn = 9'd511; end
        3: begin nw = 11'd2047; gn = 9'd511; end
        4: begin nw = 11'd100; gn = 9'd300; end
        5: begin
          nw = NEUTRAL_W'($urandom_range(2000, 1000));
          gn = GAIN_W'($urandom_range(500));
        end
        default: begin
          nw = NEUTRAL_W'($urandom_range(2047));
          gn = GAIN_W'($urandom_range(511));
        end
      endcase
      write_config(nw, gn);
      mode = p * 3 / PHASES;
      send_idle_pct = (mode == 0) ? 10 : (mode == 1) ? 67 : 0;
      recv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 10 : 0;
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        if (p == 1 && k == 60) hold_off_reqs++;
        if (p == 3 && k == 90) wait_drained();
        send_byte(pick_byte());
      end
    end
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/jftm_pkg.sv
src/joystick_frame_thruster_mixer.sv
src/jftm_checker.sv
bench/jftm_checker.sv
bench/testbench.sv
